### design/eds_pkg.sv
package eds_pkg;

    localparam int COORD_W = 24;
    localparam int SUM_W   = 48;

    // magnitude of a coordinate difference, its square, and the floor root
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ACC_W   = 2 * DIFF_W;
    localparam int ROOT_W  = ACC_W / 2;
    localparam int CNT_W   = $clog2(ROOT_W);
    localparam int EXT_W   = ((SUM_W > ROOT_W) ? SUM_W : ROOT_W) + 1;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X = 2'd0,
        REG_TARGET_Y = 2'd1,
        REG_TARGET_Z = 2'd2
    } eds_reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ACCUM
    } eds_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eds_root_status_t;

endpackage

### design/euclidean_distance_sum_core.sv
// each accepted point is squared axis by axis on one shared multiplier, then goes
//   through the one-bit-per-cycle square root and an accumulate step, which waits
//   for a free output register on a last point; in_stall stays high until idle
// a finished result waits in the output register while the next point runs
// reset (rst_n low, asynchronous) clears targets, running sum and overflow flag
module euclidean_distance_sum_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [eds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eds_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [eds_pkg::COORD_W-1:0]   point_x,
    input  logic [eds_pkg::COORD_W-1:0]   point_y,
    input  logic [eds_pkg::COORD_W-1:0]   point_z,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [eds_pkg::SUM_W-1:0]     distance_sum,
    output logic                          sum_saturated
);
    import eds_pkg::*;

    eds_state_t state_reg;
    eds_state_t state_next;

    logic [COORD_W-1:0] tgt_x_reg;
    logic [COORD_W-1:0] tgt_y_reg;
    logic [COORD_W-1:0] tgt_z_reg;
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic [COORD_W-1:0] pz_reg;
    logic               last_reg;

    logic [1:0]         step_reg;
    logic [ACC_W-1:0]   prod_reg;
    logic [ACC_W-1:0]   ssq_reg;
    logic [ACC_W-1:0]   ssq_total;
    logic [SUM_W-1:0]   sum_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic               out_sat_reg;

    logic               in_accept;
    logic               out_free;
    logic               sq_last;
    logic               root_start;
    logic               accum_en;

    logic [COORD_W-1:0] t_sel;
    logic [COORD_W-1:0] p_sel;
    logic signed [DIFF_W-1:0] diff_s;
    logic [DIFF_W-1:0]  mag;

    logic [EXT_W-1:0]   sum_ext;
    logic               sum_sat;
    logic [SUM_W-1:0]   sum_new;

    eds_root_status_t   root_status;
    logic [ROOT_W-1:0]  root;

    // last square is still in prod_reg when the root starts
    assign ssq_total = ssq_reg + prod_reg;

    eds_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (ssq_total),
        .status   (root_status),
        .root     (root)
    );

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign sq_last   = (step_reg == 2'd3);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (sq_last)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_status.done)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall   = 1'b1;
        root_start = 1'b0;
        accum_en   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_SQUARE:
            begin
                root_start = sq_last;
            end
            ST_ROOT:
            begin
            end
            ST_ACCUM:
            begin
                accum_en = !last_reg || out_free;
            end
            default:
            begin
            end
        endcase
    end

    // one axis per cycle through the shared multiplier
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                t_sel = tgt_x_reg;
                p_sel = px_reg;
            end
            2'd1:
            begin
                t_sel = tgt_y_reg;
                p_sel = py_reg;
            end
            default:
            begin
                t_sel = tgt_z_reg;
                p_sel = pz_reg;
            end
        endcase
        diff_s = $signed({t_sel[COORD_W-1], t_sel}) - $signed({p_sel[COORD_W-1], p_sel});
        mag    = diff_s[DIFF_W-1] ? DIFF_W'(-diff_s) : DIFF_W'(diff_s);
    end

    // saturating add of the new distance
    always_comb
    begin
        sum_ext = EXT_W'(sum_reg) + EXT_W'(root);
        sum_sat = (sum_ext > EXT_W'({SUM_W{1'b1}}));
        sum_new = sum_sat ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tgt_x_reg     <= '0;
            tgt_y_reg     <= '0;
            tgt_z_reg     <= '0;
            step_reg      <= '0;
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TARGET_X: tgt_x_reg <= cfg_data;
                    REG_TARGET_Y: tgt_y_reg <= cfg_data;
                    REG_TARGET_Z: tgt_z_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_SQUARE)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accum_en)
            begin
                if (last_reg)
                begin
                    sum_reg       <= '0;
                    ovf_reg       <= 1'b0;
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_new;
                    ovf_reg <= ovf_reg || sum_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            px_reg   <= point_x;
            py_reg   <= point_y;
            pz_reg   <= point_z;
            last_reg <= last_point;
            ssq_reg  <= '0;
        end
        else if (state_reg == ST_SQUARE && step_reg != 2'd0)
        begin
            // prod_reg holds the registered product of the previous axis
            ssq_reg <= ssq_reg + prod_reg;
        end

        if (state_reg == ST_SQUARE)
        begin
            prod_reg <= ACC_W'(mag) * ACC_W'(mag);
        end

        if (accum_en && last_reg)
        begin
            out_sum_reg <= sum_new;
            out_sat_reg <= ovf_reg || sum_sat;
        end
    end

    assign out_valid     = out_valid_reg;
    assign distance_sum  = out_sum_reg;
    assign sum_saturated = out_sat_reg;

endmodule

### design/eds_isqrt.sv
module eds_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [eds_pkg::ACC_W-1:0]  radicand,
    output eds_pkg::eds_root_status_t  status,
    output logic [eds_pkg::ROOT_W-1:0] root
);
    import eds_pkg::*;

    logic [ACC_W-1:0]  rad_reg;
    logic [ACC_W-1:0]  rad_next;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W:0]   rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              last_iter;

    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+3:0] diff;

    // one result bit per cycle, two radicand bits brought down each step
    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[ACC_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        diff     = {1'b0, rem_sh} - {1'b0, trial};
        rad_next = {rad_reg[ACC_W-3:0], 2'b00};
        if (!diff[ROOT_W+3])
        begin
            rem_next  = diff[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh[ROOT_W:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    assign last_iter = busy_reg && (cnt_reg == CNT_W'(ROOT_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last_iter)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = last_iter;
    assign root        = root_reg;

endmodule

### verif/eds_sum_checker.sv
`timescale 1ns / 100ps

module eds_sum_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [eds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [eds_pkg::COORD_W-1:0]   cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [eds_pkg::COORD_W-1:0]   point_x,
    input  logic [eds_pkg::COORD_W-1:0]   point_y,
    input  logic [eds_pkg::COORD_W-1:0]   point_z,
    input  logic                          last_point,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [eds_pkg::SUM_W-1:0]     distance_sum,
    input  logic                          sum_saturated,
    output int                            mismatches,
    output int                            sums_owed
);
    import eds_pkg::*;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             saturated;
    } cloud_sum_t;

    cloud_sum_t         cloud_sums_q[$];
    logic [COORD_W-1:0] tgt_x;
    logic [COORD_W-1:0] tgt_y;
    logic [COORD_W-1:0] tgt_z;
    logic [SUM_W-1:0]   run_sum;
    logic               run_sat;

    function automatic logic [COORD_W:0] abs_delta(logic [COORD_W-1:0] t,
                                                   logic [COORD_W-1:0] p);
        logic signed [COORD_W:0] d;
        d = $signed({t[COORD_W-1], t}) - $signed({p[COORD_W-1], p});
        return d[COORD_W] ? -d : d;
    endfunction

    // floor of the root of the squared distance, as an integer with no fraction bits
    function automatic logic [COORD_W:0] distance_to_target(logic [COORD_W-1:0] px,
                                                            logic [COORD_W-1:0] py,
                                                            logic [COORD_W-1:0] pz);
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] sq;
        logic [63:0] trial;
        logic [63:0] root;
        ax = 64'(abs_delta(tgt_x, px));
        ay = 64'(abs_delta(tgt_y, py));
        az = 64'(abs_delta(tgt_z, pz));
        sq = ax * ax + ay * ay + az * az;
        root = '0;
        for (int b = COORD_W; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root[COORD_W:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cloud_sum_t          due;
        cloud_sum_t          owed;
        logic [SUM_W:0]      wide;
        logic [COORD_W:0]    pt_dist;
        if (!rst_n)
        begin
            tgt_x      = '0;
            tgt_y      = '0;
            tgt_z      = '0;
            run_sum    = '0;
            run_sat    = 1'b0;
            mismatches = 0;
            sums_owed  = 0;
            cloud_sums_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_TARGET_X: tgt_x = cfg_data;
                    REG_TARGET_Y: tgt_y = cfg_data;
                    REG_TARGET_Z: tgt_z = cfg_data;
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                if (cloud_sums_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, none pending: %s %h %s %b",
                             $time, "distance_sum", distance_sum,
                             "sum_saturated", sum_saturated);
                end
                else
                begin
                    due = cloud_sums_q.pop_front();
                    if (distance_sum !== due.sum)
                    begin
                        mismatches++;
                        $display("%0t: distance_sum expected %h actual %h",
                                 $time, due.sum, distance_sum);
                    end
                    if (sum_saturated !== due.saturated)
                    begin
                        mismatches++;
                        $display("%0t: sum_saturated expected %b actual %b",
                                 $time, due.saturated, sum_saturated);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                pt_dist = distance_to_target(point_x, point_y, point_z);
                wide = {1'b0, run_sum} + (SUM_W+1)'(pt_dist);
                if (wide[SUM_W])
                begin
                    run_sum = '1;
                    run_sat = 1'b1;
                end
                else
                    run_sum = wide[SUM_W-1:0];
                if (last_point)
                begin
                    owed.sum       = run_sum;
                    owed.saturated = run_sat;
                    cloud_sums_q   = {cloud_sums_q, owed};
                    run_sum = '0;
                    run_sat = 1'b0;
                end
            end

            sums_owed = cloud_sums_q.size();
        end
    end

endmodule

### verif/tb_euclidean_distance_sum_core.sv
`timescale 1ns / 100ps

module tb_euclidean_distance_sum_core;
    import eds_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [COORD_W-1:0]   point_x = '0;
    logic [COORD_W-1:0]   point_y = '0;
    logic [COORD_W-1:0]   point_z = '0;
    logic                 last_point = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [SUM_W-1:0]     distance_sum;
    logic                 sum_saturated;

    int mismatches;
    int sums_owed;
    int cycle_count = 0;
    int holds_asked = 0;
    bit idle_on = 1'b1;
    int send_calm = 0;
    logic [COORD_W-1:0] tgt_x = '0;
    logic [COORD_W-1:0] tgt_y = '0;
    logic [COORD_W-1:0] tgt_z = '0;

    euclidean_distance_sum_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance_sum (distance_sum),
        .sum_saturated(sum_saturated)
    );

    eds_sum_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance_sum (distance_sum),
        .sum_saturated(sum_saturated),
        .mismatches   (mismatches),
        .sums_owed    (sums_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall bursts, quiet stretches, and requested long holds
    initial
    begin
        int holds_served;
        int hold_left;
        int burst_left;
        int calm_left;
        logic stall_next;
        holds_served = 0;
        hold_left = 0;
        burst_left = 0;
        calm_left = 0;
        forever
        begin
            @(negedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 29) == 0)
                calm_left = $urandom_range(10, 60);
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                stall_next = 1'b1;
            end
            else if (idle_on && calm_left == 0 && $urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(1, 6) - 1;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            out_stall <= stall_next;
        end
    end

    // called and returns at a falling edge; valid stays up unless the next call inserts a random gap
    task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic last);
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 29) == 0)
            send_calm = $urandom_range(10, 40);
        if (idle_on && send_calm == 0 && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        point_x    <= x;
        point_y    <= y;
        point_z    <= z;
        last_point <= last;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_targets(input logic [COORD_W-1:0] tx, input logic [COORD_W-1:0] ty,
                                 input logic [COORD_W-1:0] tz, input bit poke_spare);
        cfg_write <= 1'b1;
        cfg_index <= REG_TARGET_X;
        cfg_data  <= tx;
        @(negedge clk);
        cfg_index <= REG_TARGET_Y;
        cfg_data  <= ty;
        @(negedge clk);
        cfg_index <= REG_TARGET_Z;
        cfg_data  <= tz;
        @(negedge clk);
        // unmapped index must leave the targets alone
        if (poke_spare)
        begin
            cfg_index <= REG_SPARE;
            cfg_data  <= COORD_W'($urandom());
            @(negedge clk);
        end
        cfg_write <= 1'b0;
        tgt_x = tx;
        tgt_y = ty;
        tgt_z = tz;
    endtask

    // drain every pending sum, then give the last non-final point time to finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sums_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(logic [COORD_W-1:0] tgt);
        case ($urandom_range(0, 19))
            12, 13, 14, 15, 16: return COORD_W'($urandom());
            17: return COORD_MAX;
            18: return COORD_MIN;
            19: return tgt;
            default: return tgt + COORD_W'($urandom_range(0, 2047)) - 24'd1024;
        endcase
    endfunction

    task automatic run_clouds(input int n_points, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_points)
        begin
            len = $urandom_range(1, max_len);
            for (int i = 0; i < len; i++)
                send_point(pick_coord(tgt_x), pick_coord(tgt_y), pick_coord(tgt_z),
                           i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // targets at reset value: zero, exact root, floored root, extremes
        send_point(24'd0, 24'd0, 24'd0, 1'b1);
        send_point(24'd3, 24'd4, 24'd0, 1'b1);
        send_point(24'd1, 24'd1, 24'd1, 1'b1);
        send_point(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_point(24'h000100, 24'd0, 24'd0, 1'b1);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        settle();

        write_targets(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, 24'd0, COORD_MAX, 1'b0);
        send_point(24'h123456, 24'hABCDEF, 24'h55AA55, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        settle();

        write_targets(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        send_point(24'h000000, 24'hFFFFFF, 24'h7F0000, 1'b1);
        settle();

        // saturation would need millions of points, so the flag stays low here
        write_targets(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()), 1'b1);
        run_clouds(150, 6);
        settle();

        write_targets(COORD_MAX, COORD_MIN, 24'd0, 1'b0);
        run_clouds(140, 6);
        settle();

        // long result hold while single-point clouds keep coming
        write_targets(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()), 1'b1);
        holds_asked++;
        run_clouds(30, 1);
        run_clouds(120, 6);
        settle();

        write_targets(COORD_W'($urandom_range(0, 4095)),
                      COORD_W'(24'hFFFFFF - $urandom_range(0, 4095)),
                      COORD_W'($urandom_range(0, 255)), 1'b0);
        run_clouds(150, 8);
        settle();

        idle_on = 1'b0;
        write_targets(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()), 1'b1);
        run_clouds(140, 6);
        settle();

        if (mismatches == 0 && sums_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### euclidean_distance_sum_core.f
design/eds_pkg.sv
design/eds_isqrt.sv
design/euclidean_distance_sum_core.sv
verif/eds_sum_checker.sv
verif/tb_euclidean_distance_sum_core.sv
